// ----- rtl/core/cmsc_pkg.sv -----
package cmsc_pkg;

    localparam int unsigned MaxShift   = 32;
    localparam int unsigned WordW      = 32;
    localparam int unsigned ShiftW     = 6;
    localparam int unsigned DvdW       = 2 * WordW;
    localparam int unsigned CntW       = $clog2(DvdW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_LIMIT,
        ST_LOAD,
        ST_DIV,
        ST_CHECK
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic finish;
        logic fits;
    } t_ctrl;

endpackage

// ----- rtl/core/clock_mult_shift_calc_top.sv -----
// Channel  | Direction | Signals
// ---------+-----------+--------------------------------------------------------
// in       | input     | i_in_valid, o_in_ready, i_from_hz, i_to_hz, i_range_sec
// out      | output    | o_out_valid, i_out_ready, o_multiplier, o_shift_amount,
//          |           | o_bad_input
//
// An accepted request passes the multiply state, the limit scan and n shift trials to a result:
// the scan covers b (0 to 32), the bit count of the high word of range * from, one bit a cycle,
// and n (1 to 32) the shifts tried, each a load, 64 restoring divider steps and a check.
// A zero source frequency goes from acceptance straight to the check state.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// A new request is taken only in the idle state, even with a result waiting on the output;
// the next result then waits in the check state until the output register is free.
module clock_mult_shift_calc_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cmsc_pkg::WordW-1:0]    i_from_hz,
    input  logic [cmsc_pkg::WordW-1:0]    i_to_hz,
    input  logic [cmsc_pkg::WordW-1:0]    i_range_sec,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cmsc_pkg::WordW-1:0]    o_multiplier,
    output logic [cmsc_pkg::ShiftW-1:0]   o_shift_amount,
    output logic                          o_bad_input
);

    cmsc_pkg::t_state r_state, n_state;
    cmsc_pkg::t_ctrl  ctrl;

    logic [cmsc_pkg::WordW-1:0]  r_from;
    logic [cmsc_pkg::WordW-1:0]  r_range;
    logic [cmsc_pkg::DvdW-1:0]   r_to_sh;
    logic [cmsc_pkg::WordW-1:0]  r_hi;
    logic [cmsc_pkg::ShiftW-1:0] r_limit;
    logic [cmsc_pkg::ShiftW-1:0] r_sft;
    logic [cmsc_pkg::DvdW-1:0]   r_num;
    logic [cmsc_pkg::WordW-1:0]  r_rem;
    logic [cmsc_pkg::CntW-1:0]   r_cnt;
    logic                        r_bad;
    logic                        r_out_valid;
    logic [cmsc_pkg::WordW-1:0]  r_mult_out;
    logic [cmsc_pkg::ShiftW-1:0] r_shift_out;
    logic                        r_bad_out;

    logic                        in_acc;
    logic                        out_free;
    logic [cmsc_pkg::DvdW-1:0]   prod;
    logic [cmsc_pkg::WordW:0]    rem_sh;
    logic                        q_bit;
    logic [cmsc_pkg::DvdW-1:0]   fit_mask;

    assign in_acc   = i_in_valid && ctrl.in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign prod     = {{cmsc_pkg::WordW{1'b0}}, r_range} * {{cmsc_pkg::WordW{1'b0}}, r_from};

    // One restoring division step: the remainder stays below the divisor.
    assign rem_sh = {r_rem, r_num[cmsc_pkg::DvdW-1]};
    assign q_bit  = rem_sh >= {1'b0, r_from};

    // The quotient fits when no bit at or above the limit is set.
    assign fit_mask = ~((cmsc_pkg::DvdW'(1) << r_limit) - cmsc_pkg::DvdW'(1));

    always_comb begin
        ctrl.in_ready = (r_state == cmsc_pkg::ST_IDLE);
        ctrl.fits     = ((r_num & fit_mask) == '0);
        ctrl.finish   = (r_state == cmsc_pkg::ST_CHECK)
                        && (r_bad || ctrl.fits || (r_sft == cmsc_pkg::ShiftW'(1)));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cmsc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_from_hz == '0) ? cmsc_pkg::ST_CHECK : cmsc_pkg::ST_MULT;
                end
            end
            cmsc_pkg::ST_MULT:  n_state = cmsc_pkg::ST_LIMIT;
            cmsc_pkg::ST_LIMIT: begin
                if (r_hi == '0) begin
                    n_state = cmsc_pkg::ST_LOAD;
                end
            end
            cmsc_pkg::ST_LOAD:  n_state = cmsc_pkg::ST_DIV;
            cmsc_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = cmsc_pkg::ST_CHECK;
                end
            end
            cmsc_pkg::ST_CHECK: begin
                if (ctrl.finish) begin
                    if (out_free) begin
                        n_state = cmsc_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = cmsc_pkg::ST_LOAD;
                end
            end
            default: n_state = cmsc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cmsc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctrl.finish && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cmsc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_from  <= i_from_hz;
                    r_range <= i_range_sec;
                    r_to_sh <= {i_to_hz, {cmsc_pkg::WordW{1'b0}}};
                    r_bad   <= (i_from_hz == '0);
                    r_limit <= cmsc_pkg::ShiftW'(cmsc_pkg::MaxShift);
                    r_sft   <= cmsc_pkg::ShiftW'(cmsc_pkg::MaxShift);
                end
            end
            cmsc_pkg::ST_MULT: begin
                r_hi <= prod[cmsc_pkg::DvdW-1:cmsc_pkg::WordW];
            end
            cmsc_pkg::ST_LIMIT: begin
                if (r_hi != '0) begin
                    r_hi    <= r_hi >> 1;
                    r_limit <= r_limit - cmsc_pkg::ShiftW'(1);
                end
            end
            cmsc_pkg::ST_LOAD: begin
                r_num <= r_to_sh + {{(cmsc_pkg::WordW+1){1'b0}}, r_from[cmsc_pkg::WordW-1:1]};
                r_rem <= '0;
                r_cnt <= cmsc_pkg::CntW'(cmsc_pkg::DvdW - 1);
            end
            cmsc_pkg::ST_DIV: begin
                r_num <= {r_num[cmsc_pkg::DvdW-2:0], q_bit};
                r_rem <= q_bit ? cmsc_pkg::WordW'(rem_sh - {1'b0, r_from})
                               : rem_sh[cmsc_pkg::WordW-1:0];
                r_cnt <= r_cnt - cmsc_pkg::CntW'(1);
            end
            cmsc_pkg::ST_CHECK: begin
                if (ctrl.finish) begin
                    if (out_free) begin
                        r_mult_out  <= r_bad ? '0 : r_num[cmsc_pkg::WordW-1:0];
                        r_shift_out <= (r_bad || !ctrl.fits) ? '0 : r_sft;
                        r_bad_out   <= r_bad;
                    end
                end else begin
                    r_sft   <= r_sft - cmsc_pkg::ShiftW'(1);
                    r_to_sh <= r_to_sh >> 1;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready     = ctrl.in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_multiplier   = r_mult_out;
    assign o_shift_amount = r_shift_out;
    assign o_bad_input    = r_bad_out;

    a_div_shift_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmsc_pkg::ST_DIV) |-> (r_sft != '0))
        else $error("division running with shift zero");

    a_limit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmsc_pkg::ST_LIMIT) |-> (r_limit <= cmsc_pkg::ShiftW'(cmsc_pkg::MaxShift)))
        else $error("width limit out of range");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_input) |-> (o_multiplier == '0 && o_shift_amount == '0))
        else $error("bad input result not zero");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_shift_amount <= cmsc_pkg::ShiftW'(cmsc_pkg::MaxShift)))
        else $error("shift amount out of range");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_from_hz != '0) |=> (r_state == cmsc_pkg::ST_MULT))
        else $error("accepted request did not start");

endmodule
